>>> design/hcodec_pkg.sv
// Shared types and codes for the Huffman table codec.
// Used by hcodec_front, hcodec_queue, hcodec_back and huffman_table_codec.
package hcodec_pkg;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 16;
  localparam int LEN_W  = 5;

  localparam int QUEUE_DEPTH = 2;

  // command codes on in_cmd
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NOCODE  = 2'd1;
  localparam logic [1:0] ERR_NOMATCH = 2'd2;

  // operation as classified by the front end
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ENC,
    OP_ENC_NOCODE,
    OP_DEC
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              coded_bit;
  } item_t;

endpackage

>>> design/hcodec_front.sv
// Front end: takes command words, classifies them and pushes them to the queue.
// Depends on hcodec_pkg.
module hcodec_front #(
  parameter int SYMBOL_COUNT = 256,
  parameter int LEN_LIMIT    = 16
) (
  input  logic                          start,
  input  logic [1:0]                    in_cmd,
  input  logic [hcodec_pkg::SYM_W-1:0]  in_symbol,
  input  logic [hcodec_pkg::CODE_W-1:0] in_code_bits,
  input  logic [hcodec_pkg::LEN_W-1:0]  in_code_len,
  input  logic                          in_coded_bit,
  input  logic                          q_full,
  output logic                          busy,
  output logic                          q_push,
  output hcodec_pkg::item_t             q_item
);

  logic                          accept;
  logic                          keep;
  logic                          sym_ok;
  logic [hcodec_pkg::LEN_W-1:0]  len_eff;
  logic [hcodec_pkg::CODE_W-1:0] len_mask;

  assign busy   = q_full;
  assign accept = start && !q_full;
  assign sym_ok = (9'(in_symbol) < 9'(SYMBOL_COUNT));

  // over-long codes are stored as invalid
  assign len_eff  = (in_code_len > hcodec_pkg::LEN_W'(LEN_LIMIT)) ? '0 : in_code_len;
  assign len_mask = (len_eff >= hcodec_pkg::LEN_W'(16)) ? '1 :
                    hcodec_pkg::CODE_W'((17'd1 << len_eff) - 17'd1);

  always_comb begin
    keep             = 1'b0;
    q_item.op        = hcodec_pkg::OP_DEC;
    q_item.symbol    = in_symbol;
    q_item.code      = in_code_bits & len_mask;
    q_item.len       = len_eff;
    q_item.coded_bit = in_coded_bit;
    unique case (in_cmd)
      hcodec_pkg::CMD_LOAD: begin
        keep      = sym_ok;
        q_item.op = hcodec_pkg::OP_LOAD;
      end
      hcodec_pkg::CMD_ENCODE: begin
        keep      = 1'b1;
        q_item.op = sym_ok ? hcodec_pkg::OP_ENC : hcodec_pkg::OP_ENC_NOCODE;
      end
      hcodec_pkg::CMD_DECODE: begin
        keep      = 1'b1;
        q_item.op = hcodec_pkg::OP_DEC;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // unused command codes are taken and dropped
  assign q_push = accept && keep;

endmodule

>>> design/hcodec_queue.sv
// Two-word queue between the front end and the table engine.
// Depends on hcodec_pkg.
module hcodec_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hcodec_pkg::item_t push_item,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output hcodec_pkg::item_t head_item
);

  localparam int PTR_W = (hcodec_pkg::QUEUE_DEPTH > 1) ? $clog2(hcodec_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(hcodec_pkg::QUEUE_DEPTH + 1);

  hcodec_pkg::item_t slot_r [hcodec_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == CNT_W'(hcodec_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_item = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(hcodec_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(hcodec_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/hcodec_back.sv
// Table engine: holds the code table, does loads, encode lookups and the
// per-bit decode scan. Depends on hcodec_pkg.
module hcodec_back #(
  parameter int SYMBOL_COUNT = 256,
  parameter int LEN_LIMIT    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  hcodec_pkg::item_t             q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [hcodec_pkg::SYM_W-1:0]  out_symbol,
  output logic [hcodec_pkg::CODE_W-1:0] out_code,
  output logic [hcodec_pkg::LEN_W-1:0]  out_len,
  output logic [1:0]                    out_error
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENT_W = hcodec_pkg::LEN_W + hcodec_pkg::CODE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENC,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;

  // table: {len, code}; the length store is backed by per-entry valid bits
  logic [ENT_W-1:0] tbl_mem [SYMBOL_COUNT];
  logic             vld_r   [SYMBOL_COUNT];

  logic [IDX_W-1:0]              rd_addr;
  logic [ENT_W-1:0]              rd_data_r;
  logic                          rd_vld_r;
  logic [hcodec_pkg::LEN_W-1:0]  rd_len;
  logic [hcodec_pkg::CODE_W-1:0] rd_code;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_idx;

  logic [IDX_W-1:0]              addr_r, addr_nxt;
  logic [hcodec_pkg::CODE_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [hcodec_pkg::LEN_W-1:0]  pend_cnt_r, pend_cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic [hcodec_pkg::SYM_W-1:0]  out_symbol_r, out_symbol_nxt;
  logic [hcodec_pkg::CODE_W-1:0] out_code_r, out_code_nxt;
  logic [hcodec_pkg::LEN_W-1:0]  out_len_r, out_len_nxt;
  logic [1:0]                    out_error_r, out_error_nxt;

  logic hit;

  assign wr_idx  = q_item.symbol[IDX_W-1:0];
  assign rd_len  = rd_data_r[ENT_W-1:hcodec_pkg::CODE_W];
  assign rd_code = rd_data_r[hcodec_pkg::CODE_W-1:0];
  assign hit     = rd_vld_r && (rd_len == pend_cnt_r) && (rd_code == pend_bits_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_idx] <= {q_item.len, q_item.code};
    end
    rd_data_r <= tbl_mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      vld_r[wr_idx] <= (q_item.len != '0);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    rd_addr        = addr_r;
    q_pop          = 1'b0;
    wr_en          = 1'b0;
    pend_bits_nxt  = pend_bits_r;
    pend_cnt_nxt   = pend_cnt_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_symbol_nxt = out_symbol_r;
    out_code_nxt   = out_code_r;
    out_len_nxt    = out_len_r;
    out_error_nxt  = out_error_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            hcodec_pkg::OP_LOAD: begin
              wr_en = 1'b1;
            end
            hcodec_pkg::OP_ENC: begin
              rd_addr   = wr_idx;
              state_nxt = S_ENC;
            end
            hcodec_pkg::OP_ENC_NOCODE: begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = hcodec_pkg::KIND_ENC;
              out_symbol_nxt = '0;
              out_code_nxt   = '0;
              out_len_nxt    = '0;
              out_error_nxt  = hcodec_pkg::ERR_NOCODE;
            end
            hcodec_pkg::OP_DEC: begin
              pend_bits_nxt = {pend_bits_r[hcodec_pkg::CODE_W-2:0], q_item.coded_bit};
              pend_cnt_nxt  = pend_cnt_r + 1'b1;
              rd_addr       = '0;
              addr_nxt      = '0;
              state_nxt     = S_SCAN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ENC: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = hcodec_pkg::KIND_ENC;
        out_symbol_nxt = '0;
        out_code_nxt   = rd_vld_r ? rd_code : '0;
        out_len_nxt    = rd_vld_r ? rd_len : '0;
        out_error_nxt  = rd_vld_r ? hcodec_pkg::ERR_NONE : hcodec_pkg::ERR_NOCODE;
        state_nxt      = S_IDLE;
      end
      S_SCAN: begin
        // rd_data_r holds the entry at addr_r; first hit is the lowest symbol
        if (hit) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = hcodec_pkg::KIND_DEC;
          out_symbol_nxt = hcodec_pkg::SYM_W'(addr_r);
          out_code_nxt   = pend_bits_r;
          out_len_nxt    = pend_cnt_r;
          out_error_nxt  = hcodec_pkg::ERR_NONE;
          pend_bits_nxt  = '0;
          pend_cnt_nxt   = '0;
          state_nxt      = S_IDLE;
        end else if (addr_r == IDX_W'(SYMBOL_COUNT - 1)) begin
          if (pend_cnt_r >= hcodec_pkg::LEN_W'(LEN_LIMIT)) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = hcodec_pkg::KIND_DEC;
            out_symbol_nxt = '0;
            out_code_nxt   = pend_bits_r;
            out_len_nxt    = pend_cnt_r;
            out_error_nxt  = hcodec_pkg::ERR_NOMATCH;
            pend_bits_nxt  = '0;
            pend_cnt_nxt   = '0;
          end
          state_nxt = S_IDLE;
        end else begin
          rd_addr  = addr_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    out_kind_r   <= out_kind_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_code_r   <= out_code_nxt;
    out_len_r    <= out_len_nxt;
    out_error_r  <= out_error_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_symbol = out_symbol_r;
  assign out_code   = out_code_r;
  assign out_len    = out_len_r;
  assign out_error  = out_error_r;

endmodule

>>> design/huffman_table_codec.sv
// Top level of the Huffman table codec: front end, queue and table engine.
// Depends on hcodec_pkg, hcodec_front, hcodec_queue, hcodec_back.
//
//  channel   handshake             payload
//  -------   -------------------   ---------------------------------------------
//  in        start & !busy         in_cmd in_symbol in_code_bits in_code_len
//                                  in_coded_bit
//  out       out_valid (1 cycle)   out_kind out_symbol out_code out_len out_error
//
// Load writes the table from the idle state; encode does one registered table read.
// Decode of one bit scans the table one entry a cycle through its single read
// port, from entry 0 to the last entry, stopping early when an entry matches.
// A two-word queue lets the front end take words while the engine scans;
// busy is high while the queue is full. Results cannot be held off.
// Synchronous reset clears the entry valid bits at once; no clearing pass.
module huffman_table_codec #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [hcodec_pkg::SYM_W-1:0]  in_symbol,
  input  logic [hcodec_pkg::CODE_W-1:0] in_code_bits,
  input  logic [hcodec_pkg::LEN_W-1:0]  in_code_len,
  input  logic                          in_coded_bit,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [hcodec_pkg::SYM_W-1:0]  out_symbol,
  output logic [hcodec_pkg::CODE_W-1:0] out_code,
  output logic [hcodec_pkg::LEN_W-1:0]  out_len,
  output logic [1:0]                    out_error
);

  localparam int LEN_LIMIT = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_not_empty;
  hcodec_pkg::item_t push_item;
  hcodec_pkg::item_t head_item;

  hcodec_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .LEN_LIMIT    (LEN_LIMIT)
  ) u_front (
    .start        (start),
    .in_cmd       (in_cmd),
    .in_symbol    (in_symbol),
    .in_code_bits (in_code_bits),
    .in_code_len  (in_code_len),
    .in_coded_bit (in_coded_bit),
    .q_full       (q_full),
    .busy         (busy),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  hcodec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  hcodec_back #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .LEN_LIMIT    (LEN_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_kind   (out_kind),
    .out_symbol (out_symbol),
    .out_code   (out_code),
    .out_len    (out_len),
    .out_error  (out_error)
  );

endmodule

>>> tb/sv/tb_huffman_table_codec.sv
// Self-checking testbench for huffman_table_codec: directed table, then random code tables.
// Each accepted word is run through a local copy of the table and accumulator.
// Depends on hcodec_pkg and the huffman_table_codec RTL.
`timescale 1ns / 100ps

module tb_huffman_table_codec;

  localparam int SYM_W       = hcodec_pkg::SYM_W;
  localparam int CODE_W      = hcodec_pkg::CODE_W;
  localparam int LEN_W       = hcodec_pkg::LEN_W;
  localparam int TABLE_SIZE  = 256;
  localparam int LEN_LIMIT   = 16;
  localparam int WORD_TARGET = 1900;
  localparam int CYCLE_LIMIT = 3_000_000;
  // a word with no result may still be scanning the table, plus the queued words behind it
  localparam int TAIL_CYCLES = (hcodec_pkg::QUEUE_DEPTH + 2) * (TABLE_SIZE + 8);

  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [1:0]        err;
  } codec_res_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] cbits;
    logic [LEN_W-1:0]  clen;
    logic              cbit;
    logic [4:0]        reps;
    logic              typed;
    codec_res_t        want;
  } stim_row_t;

  localparam codec_res_t NO_RESP = '0;

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                start        = 1'b0;
  logic [1:0]          in_cmd       = '0;
  logic [SYM_W-1:0]    in_symbol    = '0;
  logic [CODE_W-1:0]   in_code_bits = '0;
  logic [LEN_W-1:0]    in_code_len  = '0;
  logic                in_coded_bit = 1'b0;
  logic                busy;
  logic                out_valid;
  logic                out_kind;
  logic [SYM_W-1:0]    out_symbol;
  logic [CODE_W-1:0]   out_code;
  logic [LEN_W-1:0]    out_len;
  logic [1:0]          out_error;

  // local copy of the code table and the decode accumulator
  bit [CODE_W-1:0]     tbl_code [TABLE_SIZE];
  bit [LEN_W-1:0]      tbl_len  [TABLE_SIZE];
  logic [CODE_W-1:0]   acc_bits  = '0;
  logic [LEN_W-1:0]    acc_count = '0;

  codec_res_t          due_responses[$];
  stim_row_t           dir_rows[$];
  codec_res_t          seen_resp;
  codec_res_t          want_resp;
  int                  bad_responses = 0;
  int                  words_sent    = 0;
  int                  cycle_count   = 0;
  bit                  idle_on       = 1'b0;
  bit                  sender_parked = 1'b1;

  huffman_table_codec dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_symbol    (in_symbol),
    .in_code_bits (in_code_bits),
    .in_code_len  (in_code_len),
    .in_coded_bit (in_coded_bit),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_symbol   (out_symbol),
    .out_code     (out_code),
    .out_len      (out_len),
    .out_error    (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic codec_res_t mk_resp(input logic kind, input logic [SYM_W-1:0] sym,
                                         input logic [CODE_W-1:0] code,
                                         input logic [LEN_W-1:0] len, input logic [1:0] err);
    codec_res_t r;
    r.kind = kind;
    r.sym  = sym;
    r.code = code;
    r.len  = len;
    r.err  = err;
    return r;
  endfunction

  // applies one word to the local table state and gives the result it should cause
  function automatic void codec_response(input logic [1:0] cmd, input logic [SYM_W-1:0] sym,
                                         input logic [CODE_W-1:0] cbits,
                                         input logic [LEN_W-1:0] clen, input logic cbit,
                                         output bit fired, output codec_res_t resp);
    logic [LEN_W-1:0]  n;
    logic [LEN_W-1:0]  cnt;
    logic [CODE_W-1:0] acc;
    logic [31:0]       mask;
    int                i;
    fired = 1'b0;
    resp  = NO_RESP;
    case (cmd)
      hcodec_pkg::CMD_LOAD: begin
        n = (clen > LEN_LIMIT) ? '0 : clen;
        mask = (32'd1 << n) - 32'd1;
        tbl_len[sym]  = n;
        tbl_code[sym] = cbits & mask[CODE_W-1:0];
      end
      hcodec_pkg::CMD_ENCODE: begin
        fired = 1'b1;
        if (tbl_len[sym] != 0)
          resp = mk_resp(hcodec_pkg::KIND_ENC, '0, tbl_code[sym], tbl_len[sym],
                         hcodec_pkg::ERR_NONE);
        else
          resp = mk_resp(hcodec_pkg::KIND_ENC, '0, '0, '0, hcodec_pkg::ERR_NOCODE);
      end
      hcodec_pkg::CMD_DECODE: begin
        cnt = acc_count + 5'd1;
        acc = {acc_bits[CODE_W-2:0], cbit};
        acc_bits  = acc;
        acc_count = cnt;
        // lowest symbol wins when codes overlap
        for (i = 0; i < TABLE_SIZE; i++) begin
          if (!fired && tbl_len[i] != 0 && tbl_len[i] == cnt && tbl_code[i] == acc) begin
            fired = 1'b1;
            resp  = mk_resp(hcodec_pkg::KIND_DEC, i[SYM_W-1:0], acc, cnt,
                            hcodec_pkg::ERR_NONE);
          end
        end
        if (!fired && cnt >= LEN_LIMIT) begin
          fired = 1'b1;
          resp  = mk_resp(hcodec_pkg::KIND_DEC, '0, acc, cnt, hcodec_pkg::ERR_NOMATCH);
        end
        if (fired) begin
          acc_bits  = '0;
          acc_count = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic issue_word(input logic [1:0] cmd, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] cbits, input logic [LEN_W-1:0] clen,
                            input logic cbit, input logic typed, input codec_res_t want);
    bit         fired;
    codec_res_t resp;
    int         gap;
    start         <= 1'b1;
    sender_parked  = 1'b0;
    in_cmd        <= cmd;
    in_symbol     <= sym;
    in_code_bits  <= cbits;
    in_code_len   <= clen;
    in_coded_bit  <= cbit;
    do @(posedge clk); while (busy);
    codec_response(cmd, sym, cbits, clen, cbit, fired, resp);
    if (typed)
      due_responses.push_back(want);
    else if (fired)
      due_responses.push_back(resp);
    words_sent++;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start         <= 1'b0;
      sender_parked  = 1'b1;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] cbits,
                            input logic [LEN_W-1:0] clen);
    issue_word(hcodec_pkg::CMD_LOAD, sym, cbits, clen, 1'($urandom), 1'b0, NO_RESP);
  endtask

  task automatic encode_sym(input logic [SYM_W-1:0] sym);
    issue_word(hcodec_pkg::CMD_ENCODE, sym, CODE_W'($urandom), LEN_W'($urandom),
               1'($urandom), 1'b0, NO_RESP);
  endtask

  task automatic decode_bit(input logic b);
    issue_word(hcodec_pkg::CMD_DECODE, SYM_W'($urandom), CODE_W'($urandom),
               LEN_W'($urandom), b, 1'b0, NO_RESP);
  endtask

  task automatic drain_responses();
    if (!sender_parked) begin
      start         <= 1'b0;
      sender_parked  = 1'b1;
      @(posedge clk);
    end
    while (due_responses.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(input logic [1:0] cmd, input logic [SYM_W-1:0] sym,
                                  input logic [CODE_W-1:0] cbits, input logic [LEN_W-1:0] clen,
                                  input logic cbit, input logic [4:0] reps, input logic typed,
                                  input codec_res_t want);
    stim_row_t r;
    r.cmd   = cmd;
    r.sym   = sym;
    r.cbits = cbits;
    r.clen  = clen;
    r.cbit  = cbit;
    r.reps  = reps;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen_resp = mk_resp(out_kind, out_symbol, out_code, out_len, out_error);
      if (due_responses.size() == 0) begin
        if (bad_responses < 10)
          $display("unexpected result at cycle %0d: kind %0d sym %0d code %h len %0d err %0d",
                   cycle_count, seen_resp.kind, seen_resp.sym, seen_resp.code, seen_resp.len,
                   seen_resp.err);
        bad_responses++;
      end else begin
        want_resp = due_responses.pop_front();
        if (seen_resp.kind !== want_resp.kind || seen_resp.sym !== want_resp.sym ||
            seen_resp.code !== want_resp.code || seen_resp.len !== want_resp.len ||
            seen_resp.err !== want_resp.err) begin
          if (bad_responses < 10) begin
            $write("mismatch at cycle %0d: exp kind %0d sym %0d code %h len %0d err %0d,",
                   cycle_count, want_resp.kind, want_resp.sym, want_resp.code,
                   want_resp.len, want_resp.err);
            $display(" got kind %0d sym %0d code %h len %0d err %0d",
                     seen_resp.kind, seen_resp.sym, seen_resp.code, seen_resp.len,
                     seen_resp.err);
          end
          bad_responses++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CODE_W-1:0] leaf_code[$];
    int                leaf_len[$];
    logic [SYM_W-1:0]  leaf_sym[$];
    logic [CODE_W-1:0] junk;
    bit [TABLE_SIZE-1:0] taken;
    int                nleaf, k, s, b, drop, r;
    bit                first_phase;

    // directed part: reset state, extremes, masking, invalid lengths, overlap, no-match
    add_row(hcodec_pkg::CMD_ENCODE, 8'd0,   16'h0000, 5'd0,  1'b0, 5'd1, 1'b1,
            mk_resp(hcodec_pkg::KIND_ENC, 8'd0, 16'h0000, 5'd0, hcodec_pkg::ERR_NOCODE));
    add_row(hcodec_pkg::CMD_ENCODE, 8'd255, 16'hFFFF, 5'd31, 1'b1, 5'd1, 1'b1,
            mk_resp(hcodec_pkg::KIND_ENC, 8'd0, 16'h0000, 5'd0, hcodec_pkg::ERR_NOCODE));
    add_row(hcodec_pkg::CMD_LOAD,   8'd255, 16'hFFFF, 5'd16, 1'b0, 5'd1, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_ENCODE, 8'd255, 16'h0000, 5'd0,  1'b0, 5'd1, 1'b1,
            mk_resp(hcodec_pkg::KIND_ENC, 8'd0, 16'hFFFF, 5'd16, hcodec_pkg::ERR_NONE));
    add_row(hcodec_pkg::CMD_LOAD,   8'd0,   16'hFFFF, 5'd1,  1'b1, 5'd1, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_ENCODE, 8'd0,   16'hFFFF, 5'd31, 1'b1, 5'd1, 1'b1,
            mk_resp(hcodec_pkg::KIND_ENC, 8'd0, 16'h0001, 5'd1, hcodec_pkg::ERR_NONE));
    add_row(hcodec_pkg::CMD_LOAD,   8'd7,   16'h1234, 5'd31, 1'b0, 5'd1, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_ENCODE, 8'd7,   16'h0000, 5'd0,  1'b0, 5'd1, 1'b1,
            mk_resp(hcodec_pkg::KIND_ENC, 8'd0, 16'h0000, 5'd0, hcodec_pkg::ERR_NOCODE));
    add_row(CMD_SPARE,              8'hA5,  16'h5A5A, 5'd5,  1'b1, 5'd1, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_DECODE, 8'hFF,  16'hFFFF, 5'd31, 1'b1, 5'd1, 1'b1,
            mk_resp(hcodec_pkg::KIND_DEC, 8'd0, 16'h0001, 5'd1, hcodec_pkg::ERR_NONE));
    add_row(hcodec_pkg::CMD_LOAD,   8'd3,   16'h0001, 5'd1,  1'b0, 5'd1, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_DECODE, 8'd0,   16'h0000, 5'd0,  1'b1, 5'd1, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_LOAD,   8'd0,   16'h5555, 5'd0,  1'b0, 5'd1, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_DECODE, 8'd0,   16'h0000, 5'd0,  1'b1, 5'd1, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_LOAD,   8'd3,   16'h0000, 5'd0,  1'b0, 5'd1, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_DECODE, 8'd0,   16'h0000, 5'd0,  1'b0, 5'd15, 1'b0, NO_RESP);
    add_row(hcodec_pkg::CMD_DECODE, 8'd0,   16'h0000, 5'd0,  1'b0, 5'd1, 1'b1,
            mk_resp(hcodec_pkg::KIND_DEC, 8'd0, 16'h0000, 5'd16, hcodec_pkg::ERR_NOMATCH));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    foreach (dir_rows[i])
      repeat (dir_rows[i].reps)
        issue_word(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].cbits, dir_rows[i].clen,
                   dir_rows[i].cbit, dir_rows[i].typed, dir_rows[i].want);

    first_phase = 1'b1;
    while (words_sent < WORD_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (!first_phase && $urandom_range(0, 7) == 0) begin
        // noise: arbitrary loads, lookups, stray bits and the unused command
        repeat ($urandom_range(20, 40)) begin
          r = $urandom_range(0, 9);
          if (r < 3)
            load_entry(SYM_W'($urandom), CODE_W'($urandom),
                       ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(17, 31))
                                                   : LEN_W'($urandom_range(0, 16)));
          else if (r < 5)
            encode_sym(SYM_W'($urandom));
          else if (r < 9)
            decode_bit(1'($urandom));
          else
            issue_word(CMD_SPARE, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
                       1'($urandom), 1'b0, NO_RESP);
        end
      end else begin
        // wipe whatever is live, then load a fresh prefix-free code
        for (s = 0; s < TABLE_SIZE; s++)
          if (tbl_len[s] != 0)
            load_entry(s[SYM_W-1:0], CODE_W'($urandom), 5'd0);

        leaf_code.delete();
        leaf_len.delete();
        leaf_sym.delete();
        leaf_code.push_back('0);
        leaf_len.push_back(0);
        nleaf = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200) : $urandom_range(2, 16);
        repeat (nleaf - 1) begin
          // splitting the newest leaf now and then grows long codes
          k = ($urandom_range(0, 2) == 0) ? leaf_code.size() - 1
                                          : $urandom_range(0, leaf_code.size() - 1);
          while (leaf_len[k] >= LEN_LIMIT) k = $urandom_range(0, leaf_code.size() - 1);
          leaf_code.push_back({leaf_code[k][CODE_W-2:0], 1'b1});
          leaf_len.push_back(leaf_len[k] + 1);
          leaf_code[k] = {leaf_code[k][CODE_W-2:0], 1'b0};
          leaf_len[k]  = leaf_len[k] + 1;
        end

        taken = '0;
        for (k = 0; k < leaf_code.size(); k++) begin
          do s = $urandom_range(0, TABLE_SIZE - 1); while (taken[s]);
          taken[s] = 1'b1;
          leaf_sym.push_back(s[SYM_W-1:0]);
        end

        // an incomplete code leaves a path that can only end in a no-match
        drop = ($urandom_range(0, 2) == 0) ? $urandom_range(0, leaf_code.size() - 1) : -1;
        for (k = 0; k < leaf_code.size(); k++) begin
          if (k != drop) begin
            junk = CODE_W'($urandom);
            junk = junk << leaf_len[k];
            load_entry(leaf_sym[k], leaf_code[k] | junk, LEN_W'(leaf_len[k]));
          end
        end

        repeat ($urandom_range(5, 25)) begin
          k = $urandom_range(0, leaf_code.size() - 1);
          if ($urandom_range(0, 3) == 0)
            encode_sym(leaf_sym[k]);
          if ($urandom_range(0, 15) == 0)
            encode_sym(SYM_W'($urandom));
          if ($urandom_range(0, 19) == 0)
            decode_bit(1'($urandom));
          for (b = leaf_len[k] - 1; b >= 0; b--)
            decode_bit(leaf_code[k][b]);
        end
      end

      if (first_phase || $urandom_range(0, 2) == 0)
        drain_responses();
      first_phase = 1'b0;
    end

    drain_responses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_responses == 0 && due_responses.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
